// ----- sv/smc_pkg.sv -----
// shared constants, types and helper functions of the six-axis motion conditioner
package smc_pkg;

   // sample and gain format
   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 12;

   // axes and configuration layout
   localparam int NAXES          = 6;
   localparam int AXIS_SEL_WIDTH = $clog2(NAXES);
   localparam int MAP_WIDTH      = AXIS_SEL_WIDTH * NAXES;
   localparam int SLIDER_WIDTH   = 7;
   localparam int SLIDER_LIMIT   = 50;
   localparam int SENS_WIDTH     = SLIDER_WIDTH * NAXES;

   localparam logic [MAP_WIDTH-1:0] MAP_RESET = MAP_WIDTH'(181896);

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = SENS_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_MAP      = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOMINANT_MODE = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLIP_YZ       = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_ENABLE   = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_REVERSE  = CSR_INDEX_WIDTH'(4);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_SENS     = CSR_INDEX_WIDTH'(5);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GLOBAL_SENS   = CSR_INDEX_WIDTH'(6);

   // datapath widths
   localparam int DIFF_WIDTH       = SAMPLE_WIDTH + 1;
   localparam int GAIN_WIDTH       = GAIN_FRAC_BITS + 2;
   localparam int GPROD_WIDTH      = 2 * GAIN_WIDTH;
   localparam int MUL_A_WIDTH      = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH;
   localparam int MUL_B_WIDTH      = GPROD_WIDTH;
   localparam int PROD_WIDTH       = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int QUOT_WIDTH       = PROD_WIDTH - 2 * GAIN_FRAC_BITS;
   localparam int GAIN_ENTRIES     = 2 * SLIDER_LIMIT + 1;
   localparam int GAIN_INDEX_WIDTH = $clog2(GAIN_ENTRIES);

   typedef logic signed [SAMPLE_WIDTH-1:0]   sample_type;
   typedef logic signed [DIFF_WIDTH-1:0]     diff_type;
   typedef sample_type                       sample_vec_type [NAXES];
   typedef diff_type                         diff_vec_type [NAXES];
   typedef logic [GAIN_WIDTH-1:0]            gain_type;
   typedef logic [GAIN_INDEX_WIDTH-1:0]      gidx_type;
   typedef logic signed [SLIDER_WIDTH-1:0]   slider_type;
   typedef logic [AXIS_SEL_WIDTH-1:0]        axis_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [MAP_WIDTH-1:0]  axis_map;
      logic                  dominant_mode;
      logic                  flip_yz;
      logic [NAXES-1:0]      axis_enable;
      logic [NAXES-1:0]      axis_reverse;
      logic [SENS_WIDTH-1:0] axis_sensitivity;
      slider_type            global_sensitivity;
   } cfg_type;

   // sequencer to front end
   typedef struct packed {
      logic load;
      logic prep;
      logic dom;
   } front_ctrl_type;

   // front end to sequencer
   typedef struct packed {
      logic capture;
   } front_stat_type;

   // gain for a slider position, evaluated at elaboration to fill the gain table
   function automatic gain_type gain_calc(input int v);
      longint one;
      longint g;
      one = longint'(1) << GAIN_FRAC_BITS;
      if (v < 0) begin
         g = (2 * one * (500 + 9 * v) + 500) / 1000;
      end else begin
         g = (2 * one * (100 + 5 * v) + 100) / 200;
      end
      return GAIN_WIDTH'(g);
   endfunction

   // clamp a slider to its legal span and turn it into a gain table index
   function automatic gidx_type slider_index(input slider_type s);
      logic signed [SLIDER_WIDTH:0] wide;
      gidx_type                     idx;
      wide = (SLIDER_WIDTH+1)'(s) + (SLIDER_WIDTH+1)'(SLIDER_LIMIT);
      priority if (wide < 0) begin
         idx = '0;
      end else if (wide > (SLIDER_WIDTH+1)'(2 * SLIDER_LIMIT)) begin
         idx = GAIN_INDEX_WIDTH'(2 * SLIDER_LIMIT);
      end else begin
         idx = GAIN_INDEX_WIDTH'(wide);
      end
      return idx;
   endfunction

endpackage

// ----- sv/smc_csr.sv -----
// configuration register file of the six-axis motion conditioner
module smc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [smc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [smc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output smc_pkg::cfg_type                     cfg
);
   import smc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_map           <= MAP_RESET;
         cfg_ff.dominant_mode      <= 1'b0;
         cfg_ff.flip_yz            <= 1'b0;
         cfg_ff.axis_enable        <= '1;
         cfg_ff.axis_reverse       <= '0;
         cfg_ff.axis_sensitivity   <= '0;
         cfg_ff.global_sensitivity <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_AXIS_MAP:      cfg_ff.axis_map         <= csr_wdata[MAP_WIDTH-1:0];
            CSR_DOMINANT_MODE: cfg_ff.dominant_mode    <= csr_wdata[0];
            CSR_FLIP_YZ:       cfg_ff.flip_yz          <= csr_wdata[0];
            CSR_AXIS_ENABLE:   cfg_ff.axis_enable      <= csr_wdata[NAXES-1:0];
            CSR_AXIS_REVERSE:  cfg_ff.axis_reverse     <= csr_wdata[NAXES-1:0];
            CSR_AXIS_SENS:     cfg_ff.axis_sensitivity <= csr_wdata[SENS_WIDTH-1:0];
            CSR_GLOBAL_SENS: begin
               cfg_ff.global_sensitivity <= slider_type'(csr_wdata[SLIDER_WIDTH-1:0]);
            end
            default: ; // unknown index, write dropped
         endcase
      end
   end

endmodule

// ----- sv/smc_front.sv -----
// sample capture, axis remap, offset store, y/z swap and dominant-axis filter
module smc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  smc_pkg::front_ctrl_type ctrl,
   input  smc_pkg::cfg_type        cfg,
   input  smc_pkg::sample_vec_type sample,
   input  logic                    capture,
   output smc_pkg::front_stat_type stat,
   output smc_pkg::diff_vec_type   v
);
   import smc_pkg::*;

   axis_type                src [NAXES];
   logic [NAXES-1:0]        seen;
   logic                    map_ok;
   sample_vec_type          remap;
   diff_vec_type            diff;
   diff_vec_type            flipped;
   diff_vec_type            dominated;
   diff_vec_type            v_in;
   logic [SAMPLE_WIDTH-1:0] mag [NAXES];
   logic [SAMPLE_WIDTH-1:0] bmag;
   axis_type                best;

   sample_vec_type          raw_ff;
   sample_vec_type          offset_ff;
   diff_vec_type            v_ff;
   logic                    capture_ff;

   // permutation check and remap straight from the incoming beat
   always_comb begin
      map_ok = 1'b1;
      seen   = '0;
      for (int i = 0; i < NAXES; i++) begin
         src[i] = cfg.axis_map[AXIS_SEL_WIDTH*i +: AXIS_SEL_WIDTH];
         if (src[i] >= AXIS_SEL_WIDTH'(NAXES)) begin
            map_ok = 1'b0;
         end else begin
            seen[src[i]] = 1'b1;
         end
      end
      map_ok = map_ok && (&seen);
      for (int i = 0; i < NAXES; i++) begin
         remap[i] = map_ok ? sample[src[i]] : sample[i];
      end
   end

   // offset removal and y/z swap
   always_comb begin
      for (int i = 0; i < NAXES; i++) begin
         diff[i] = DIFF_WIDTH'(raw_ff[i]) - DIFF_WIDTH'(offset_ff[i]);
      end
      flipped = diff;
      if (cfg.flip_yz) begin
         flipped[1] = diff[2];
         flipped[2] = -diff[1];
         flipped[4] = diff[5];
         flipped[5] = -diff[4];
      end
   end

   // first axis of largest magnitude survives
   always_comb begin
      best = '0;
      bmag = '0;
      for (int i = 0; i < NAXES; i++) begin
         mag[i] = v_ff[i][DIFF_WIDTH-1] ? SAMPLE_WIDTH'(-v_ff[i]) : SAMPLE_WIDTH'(v_ff[i]);
         if (mag[i] > bmag) begin
            bmag = mag[i];
            best = AXIS_SEL_WIDTH'(i);
         end
      end
      for (int i = 0; i < NAXES; i++) begin
         dominated[i] = (best == AXIS_SEL_WIDTH'(i)) ? v_ff[i] : '0;
      end
   end

   always_comb begin
      v_in = v_ff;
      priority if (ctrl.prep) begin
         for (int i = 0; i < NAXES; i++) begin
            v_in[i] = capture_ff ? DIFF_WIDTH'(raw_ff[i]) : flipped[i];
         end
      end else if (ctrl.dom) begin
         v_in = dominated;
      end else begin
         v_in = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NAXES; i++) begin
            offset_ff[i] <= '0;
         end
      end else if (ctrl.prep && capture_ff) begin
         offset_ff <= raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         raw_ff     <= remap;
         capture_ff <= capture;
      end
      v_ff <= v_in;
   end

   assign stat.capture = capture_ff;
   assign v            = v_ff;

endmodule

// ----- sv/smc_mul.sv -----
// shared registered multiplier for gain products and axis scaling
module smc_mul (
   input  logic                             clock,
   input  logic                             en,
   input  logic [smc_pkg::MUL_A_WIDTH-1:0]  a,
   input  logic [smc_pkg::MUL_B_WIDTH-1:0]  b,
   output logic [smc_pkg::PROD_WIDTH-1:0]   prod
);
   import smc_pkg::*;

   logic [PROD_WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
      end
   end

   assign prod = prod_ff;

endmodule

// ----- sv/six_axis_motion_conditioner.sv -----
// top level of the six-axis motion conditioner: sequencer, saturation and result register
//
// Takes one six-axis motion sample per beat on the req_ channel and returns one
// conditioned sample per beat on the rsp_ channel. The sample is remapped by the
// axis permutation as it is taken in. A capture beat stores the remapped sample as
// offsets and returns it unchanged; its result is registered in the finish step
// right after the prep step, and then the next beat can be taken. Any other
// beat has the offsets removed, the optional y/z swap and dominant-axis filter
// applied, and then each axis masked, optionally negated and scaled by its own gain
// times the global gain, truncated toward zero and saturated to 16 bits. All
// scaling goes through one shared multiplier that is used twice per axis (gain
// product, then sample times gain), so a normal beat steps through prep, the
// dominant-axis step when dominant mode is on, a gain and a scale step per axis,
// a last step and the finish step, where its result is registered; req_stall
// is high in every step but idle, and so also while a finished result has to
// wait. The
// result sits in its own register, so a new sample can be taken while the previous
// result is still stalled; a finished result only waits if that register is still
// full. There is no clearing pass after reset. Configuration writes are always
// taken (csr_ready tied high) and belong only in idle periods.
module six_axis_motion_conditioner (
   input  logic                                clock,
   input  logic                                reset,
   // input sample channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  smc_pkg::sample_type                 req_axis_in_0,
   input  smc_pkg::sample_type                 req_axis_in_1,
   input  smc_pkg::sample_type                 req_axis_in_2,
   input  smc_pkg::sample_type                 req_axis_in_3,
   input  smc_pkg::sample_type                 req_axis_in_4,
   input  smc_pkg::sample_type                 req_axis_in_5,
   input  logic                                req_capture_offsets,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output smc_pkg::sample_type                 rsp_axis_out_0,
   output smc_pkg::sample_type                 rsp_axis_out_1,
   output smc_pkg::sample_type                 rsp_axis_out_2,
   output smc_pkg::sample_type                 rsp_axis_out_3,
   output smc_pkg::sample_type                 rsp_axis_out_4,
   output smc_pkg::sample_type                 rsp_axis_out_5,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [smc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import smc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DOM,
      ST_GAIN,
      ST_SCALE,
      ST_LAST,
      ST_FINISH
   } state_type;

   // magnitude bounds for saturation
   localparam logic [QUOT_WIDTH-1:0] SAT_NEG_MAG = QUOT_WIDTH'(1) << (SAMPLE_WIDTH - 1);
   localparam logic [QUOT_WIDTH-1:0] SAT_POS_MAG = SAT_NEG_MAG - QUOT_WIDTH'(1);

   // settings index of an output axis, with the y/z swap applied
   function automatic axis_type flip_partner(input logic flip, input axis_type a);
      axis_type r;
      r = a;
      if (flip) begin
         unique case (a)
            AXIS_SEL_WIDTH'(1): r = AXIS_SEL_WIDTH'(2);
            AXIS_SEL_WIDTH'(2): r = AXIS_SEL_WIDTH'(1);
            AXIS_SEL_WIDTH'(4): r = AXIS_SEL_WIDTH'(5);
            AXIS_SEL_WIDTH'(5): r = AXIS_SEL_WIDTH'(4);
            default:            r = a;
         endcase
      end
      return r;
   endfunction

   // drop the fraction bits of the product, apply sign, mask and clamp
   function automatic sample_type saturate(input logic [PROD_WIDTH-1:0] p,
                                           input logic neg, input logic en);
      logic [QUOT_WIDTH-1:0] q;
      sample_type            r;
      q = p[PROD_WIDTH-1:2*GAIN_FRAC_BITS];
      priority if (!en) begin
         r = '0;
      end else if (neg) begin
         r = (q > SAT_NEG_MAG) ? SAMPLE_MIN : sample_type'(-q[SAMPLE_WIDTH-1:0]);
      end else begin
         r = (q > SAT_POS_MAG) ? SAMPLE_MAX : sample_type'(q[SAMPLE_WIDTH-1:0]);
      end
      return r;
   endfunction

   cfg_type                 cfg;
   sample_vec_type          req_sample;
   front_ctrl_type          front_ctrl;
   front_stat_type          front_stat;
   diff_vec_type            v;
   logic                    req_accept;
   logic                    rsp_free;

   // gain lookup, shared by the axis and global sliders
   gain_type                gain_rom [GAIN_ENTRIES];
   axis_type                set_idx;
   slider_type              axis_slider;
   gain_type                axis_gain;
   gain_type                glob_gain;

   // current axis operand
   diff_type                cur_v;
   logic                    cur_neg;
   logic [SAMPLE_WIDTH-1:0] cur_mag;

   // shared multiplier
   logic                    mul_en;
   logic [MUL_A_WIDTH-1:0]  mul_a;
   logic [MUL_B_WIDTH-1:0]  mul_b;
   logic [PROD_WIDTH-1:0]   prod;
   sample_type              sat_val;

   state_type               state_ff;
   axis_type                axis_ff;
   logic                    neg_ff;
   logic                    en_ff;
   sample_vec_type          res_ff;
   sample_vec_type          rsp_ff;
   logic                    rsp_valid_ff;

   for (genvar k = 0; k < GAIN_ENTRIES; k++) begin : g_gain_rom
      assign gain_rom[k] = gain_calc(k - SLIDER_LIMIT);
   end

   assign req_sample[0] = req_axis_in_0;
   assign req_sample[1] = req_axis_in_1;
   assign req_sample[2] = req_axis_in_2;
   assign req_sample[3] = req_axis_in_3;
   assign req_sample[4] = req_axis_in_4;
   assign req_sample[5] = req_axis_in_5;

   // one sample in flight at a time
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // result register free, or emptied this cycle
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign front_ctrl.load = req_accept;
   assign front_ctrl.prep = (state_ff == ST_PREP);
   assign front_ctrl.dom  = (state_ff == ST_DOM);

   smc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (front_ctrl),
      .cfg     (cfg),
      .sample  (req_sample),
      .capture (req_capture_offsets),
      .stat    (front_stat),
      .v       (v)
   );

   // enable, reverse and gain follow their axis through the y/z swap
   always_comb begin
      set_idx     = flip_partner(cfg.flip_yz, axis_ff);
      axis_slider = slider_type'(cfg.axis_sensitivity[SLIDER_WIDTH*set_idx +: SLIDER_WIDTH]);
      axis_gain   = gain_rom[slider_index(axis_slider)];
      glob_gain   = gain_rom[slider_index(cfg.global_sensitivity)];
   end

   always_comb begin
      cur_v   = v[axis_ff];
      cur_neg = cfg.axis_reverse[set_idx] ? (cur_v > 0) : (cur_v < 0);
      cur_mag = (cur_v < 0) ? SAMPLE_WIDTH'(-cur_v) : SAMPLE_WIDTH'(cur_v);
   end

   // gain cycle: axis gain times global gain; scale cycle: magnitude times that product
   always_comb begin
      mul_en = (state_ff == ST_GAIN) || (state_ff == ST_SCALE);
      if (state_ff == ST_GAIN) begin
         mul_a = MUL_A_WIDTH'(axis_gain);
         mul_b = MUL_B_WIDTH'(glob_gain);
      end else begin
         mul_a = MUL_A_WIDTH'(cur_mag);
         mul_b = prod[GPROD_WIDTH-1:0];
      end
   end

   smc_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign sat_val = saturate(prod, neg_ff, en_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // set when a finished result moves in, held while stalled, else dropped
         rsp_valid_ff <= ((state_ff == ST_FINISH) && rsp_free) || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               axis_ff <= '0;
               priority if (front_stat.capture) begin
                  state_ff <= ST_FINISH;
               end else if (cfg.dominant_mode) begin
                  state_ff <= ST_DOM;
               end else begin
                  state_ff <= ST_GAIN;
               end
            end
            ST_DOM: begin
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               // product register still holds the previous axis here
               if (axis_ff != '0) begin
                  res_ff[axis_type'(axis_ff - 1'b1)] <= sat_val;
               end
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               neg_ff <= cur_neg;
               en_ff  <= cfg.axis_enable[set_idx];
               if (axis_ff == AXIS_SEL_WIDTH'(NAXES - 1)) begin
                  state_ff <= ST_LAST;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_GAIN;
               end
            end
            ST_LAST: begin
               res_ff[NAXES-1] <= sat_val;
               state_ff        <= ST_FINISH;
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  for (int i = 0; i < NAXES; i++) begin
                     rsp_ff[i] <= front_stat.capture ?
                                  sample_type'(v[i][SAMPLE_WIDTH-1:0]) : res_ff[i];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_axis_out_0 = rsp_ff[0];
   assign rsp_axis_out_1 = rsp_ff[1];
   assign rsp_axis_out_2 = rsp_ff[2];
   assign rsp_axis_out_3 = rsp_ff[3];
   assign rsp_axis_out_4 = rsp_ff[4];
   assign rsp_axis_out_5 = rsp_ff[5];

`ifndef NO_ASSERTIONS
   // an accepted beat always starts the front-end step next
   a_accept_starts_prep: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_PREP)
      else $error("accepted beat did not enter prep");

   // a result only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");

   // each scaling multiply follows its gain multiply
   a_scale_after_gain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |-> $past(state_ff) == ST_GAIN)
      else $error("scale step without gain step");

   // axis counter stays on a real axis while the multiplier runs
   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN || state_ff == ST_SCALE) |-> axis_ff <= AXIS_SEL_WIDTH'(NAXES - 1))
      else $error("axis counter out of range");
`endif

endmodule
